### hdl/mpk_pkg.sv
// Shared widths, codes and types for the mecanum platform kinematics pipeline.
package mpk_pkg;

    localparam int DATA_W  = 32;
    localparam int COEF_W  = 31;
    localparam int FRAC_W  = 16;
    localparam int QUAD_W  = 18;
    localparam int SUM_W   = 35;
    localparam int SIDE_W  = 33;
    localparam int OP_W    = 34;
    localparam int PROD_W  = OP_W + COEF_W;
    localparam int MAG3_W  = 46;
    localparam int MAG_W   = 48;
    localparam int HALF_W  = MAG_W / 2;
    localparam int PP_W    = HALF_W + COEF_W;
    localparam int FULL_W  = PP_W + HALF_W;
    localparam int RES_W   = FULL_W - FRAC_W;
    localparam int LANES   = 4;
    localparam int STAGES  = 7;

    localparam logic [COEF_W-1:0] COEF_ONE = 31'd65536;
    localparam logic [DATA_W-1:0] SAT_POS  = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] SAT_NEG  = 32'h8000_0000;

    typedef enum logic [1:0]
    {
        REG_WHEEL_RADIUS     = 2'd0,
        REG_INV_WHEEL_RADIUS = 2'd1,
        REG_LEVER_SUM        = 2'd2,
        REG_INV_LEVER_SUM    = 2'd3
    } reg_index_t;

    typedef enum logic
    {
        CMD_BODY_TO_WHEEL = 1'b0,
        CMD_WHEEL_TO_BODY = 1'b1
    } cmd_t;

    typedef struct packed
    {
        logic en_mul;
        logic en_add;
        logic en_sat;
    } lane_ctl_t;

endpackage

### hdl/mecanum_platform_kinematics_top.sv
// Top level of the mecanum platform kinematics pipeline.
//
// Input words arrive on s_t*: s_tuser carries the command (0 body velocity
// to wheel speeds, 1 wheel speeds to body velocity), s_tdata the four
// signed Q16.16 operands. Each input word gives exactly one output word on
// m_t*: four signed Q16.16 results and a saturation flag in m_tuser.
// Configuration (wheel radius, its reciprocal, lever sum, its reciprocal)
// is written through cfg_valid/cfg_index/cfg_data, always ready, and must
// only change while the pipeline is empty.
// A word passes through every register stage before it reaches m_t*; one
// word is accepted every cycle unless a stall on m_tready fills the stages.
// The seven register stages are: pre-add, first multiply, shift and sign,
// side sums, split second multiply, recombine, saturate.
// A stall on m_tready holds the output word; s_tready drops only once all
// seven stages hold a word, and bubbles are squeezed out meanwhile.
// Reset empties the pipeline and loads 1.0 into every coefficient.
module mecanum_platform_kinematics_top
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // in_a, in_b, in_c, in_d
    input  logic [0:0]   s_tuser,   // command
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // out_a, out_b, out_c, out_d
    output logic [0:0]   m_tuser,   // saturated
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    localparam int DW = mpk_pkg::DATA_W;
    localparam int NS = mpk_pkg::STAGES;

    logic [mpk_pkg::COEF_W-1:0] wheel_radius_reg;
    logic [mpk_pkg::COEF_W-1:0] inv_wheel_radius_reg;
    logic [mpk_pkg::COEF_W-1:0] lever_sum_reg;
    logic [mpk_pkg::COEF_W-1:0] inv_lever_sum_reg;

    logic [NS:1] vld_reg;
    logic [NS:1] vld_next;
    logic [NS:1] en;
    logic [NS:0] vld_in;

    mpk_pkg::cmd_t cmd_reg [1:NS];

    // stage 1
    logic signed [DW-1:0]             in_a, in_b, in_c, in_d;
    logic signed [mpk_pkg::SUM_W-1:0] ax, bx, cx, dx;
    logic signed [mpk_pkg::SUM_W-1:0] s0, s1, s2;
    logic signed [mpk_pkg::SIDE_W-1:0] ab_sum_next, ab_dif_next;
    logic [mpk_pkg::OP_W-1:0]         op1_next [0:2];
    logic                             neg1_next [0:2];
    logic [mpk_pkg::OP_W-1:0]         op1_reg [0:2];
    logic                             neg1_reg [0:2];
    logic signed [mpk_pkg::SIDE_W-1:0] ab_sum1_reg, ab_dif1_reg;

    // stage 2
    logic [mpk_pkg::PROD_W-1:0]       prod2_next [0:2];
    logic [mpk_pkg::PROD_W-1:0]       prod2_reg [0:2];
    logic                             neg2_reg [0:2];
    logic [mpk_pkg::COEF_W-1:0]       coef2;
    logic signed [mpk_pkg::SIDE_W-1:0] ab_sum2_reg, ab_dif2_reg;

    // stage 3
    logic [mpk_pkg::MAG3_W-1:0]       mag3_next [0:2];
    logic [mpk_pkg::MAG3_W-1:0]       mag3_reg [0:2];
    logic                             neg3_reg [0:2];
    logic signed [mpk_pkg::MAG_W-1:0] kw3_next, kw3_reg;
    logic signed [mpk_pkg::SIDE_W-1:0] ab_sum3_reg, ab_dif3_reg;

    // stage 4
    logic signed [mpk_pkg::MAG_W-1:0] x4 [0:3];
    logic signed [mpk_pkg::MAG_W-1:0] ab_sum_w, ab_dif_w;
    logic [mpk_pkg::MAG_W-1:0]        mag4_next [0:3];
    logic                             neg4_next [0:3];
    logic [mpk_pkg::COEF_W-1:0]       coef4_next [0:3];
    logic [mpk_pkg::MAG_W-1:0]        mag4_reg [0:3];
    logic                             neg4_reg [0:3];
    logic [mpk_pkg::COEF_W-1:0]       coef4_reg [0:3];

    mpk_pkg::lane_ctl_t       lane_ctl;
    logic [DW-1:0]            lane_res [0:3];
    logic [mpk_pkg::LANES-1:0] lane_sat;

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wheel_radius_reg     <= mpk_pkg::COEF_ONE;
            inv_wheel_radius_reg <= mpk_pkg::COEF_ONE;
            lever_sum_reg        <= mpk_pkg::COEF_ONE;
            inv_lever_sum_reg    <= mpk_pkg::COEF_ONE;
        end
        else if (cfg_valid)
        begin
            case (mpk_pkg::reg_index_t'(cfg_index))
                mpk_pkg::REG_WHEEL_RADIUS:
                    wheel_radius_reg <= cfg_data[mpk_pkg::COEF_W-1:0];
                mpk_pkg::REG_INV_WHEEL_RADIUS:
                    inv_wheel_radius_reg <= cfg_data[mpk_pkg::COEF_W-1:0];
                mpk_pkg::REG_LEVER_SUM:
                    lever_sum_reg <= cfg_data[mpk_pkg::COEF_W-1:0];
                mpk_pkg::REG_INV_LEVER_SUM:
                    inv_lever_sum_reg <= cfg_data[mpk_pkg::COEF_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // stage enables and valid bits
    assign vld_in = {vld_reg, s_tvalid};

    always_comb
    begin
        en[NS] = !vld_reg[NS] || m_tready;
        for (int k = NS - 1; k >= 1; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
        for (int k = 1; k <= NS; k++)
        begin
            vld_next[k] = en[k] ? vld_in[k-1] : vld_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign s_tready = en[1];
    assign m_tvalid = vld_reg[NS];

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            cmd_reg[1] <= mpk_pkg::cmd_t'(s_tuser[0]);
        end
        for (int k = 2; k <= NS; k++)
        begin
            if (en[k])
            begin
                cmd_reg[k] <= cmd_reg[k-1];
            end
        end
    end

    // stage 1: pre-add and magnitudes
    assign in_a = s_tdata[DW-1:0];
    assign in_b = s_tdata[2*DW-1:DW];
    assign in_c = s_tdata[3*DW-1:2*DW];
    assign in_d = s_tdata[4*DW-1:3*DW];

    assign ax = mpk_pkg::SUM_W'(in_a);
    assign bx = mpk_pkg::SUM_W'(in_b);
    assign cx = mpk_pkg::SUM_W'(in_c);
    assign dx = mpk_pkg::SUM_W'(in_d);

    assign s0 = ax - bx - cx + dx;
    assign s1 = ax + bx + cx + dx;
    assign s2 = bx - ax - cx + dx;

    assign ab_sum_next = mpk_pkg::SIDE_W'(ax + bx);
    assign ab_dif_next = mpk_pkg::SIDE_W'(bx - ax);

    always_comb
    begin
        if (mpk_pkg::cmd_t'(s_tuser[0]) == mpk_pkg::CMD_BODY_TO_WHEEL)
        begin
            neg1_next[0] = cx[mpk_pkg::SUM_W-1];
            op1_next[0]  = cx[mpk_pkg::SUM_W-1] ? mpk_pkg::OP_W'(-cx) : mpk_pkg::OP_W'(cx);
            neg1_next[1] = 1'b0;
            op1_next[1]  = '0;
            neg1_next[2] = 1'b0;
            op1_next[2]  = '0;
        end
        else
        begin
            neg1_next[0] = s0[mpk_pkg::SUM_W-1];
            op1_next[0]  = s0[mpk_pkg::SUM_W-1] ? mpk_pkg::OP_W'(-s0) : mpk_pkg::OP_W'(s0);
            neg1_next[1] = s1[mpk_pkg::SUM_W-1];
            op1_next[1]  = s1[mpk_pkg::SUM_W-1] ? mpk_pkg::OP_W'(-s1) : mpk_pkg::OP_W'(s1);
            neg1_next[2] = s2[mpk_pkg::SUM_W-1];
            op1_next[2]  = s2[mpk_pkg::SUM_W-1] ? mpk_pkg::OP_W'(-s2) : mpk_pkg::OP_W'(s2);
        end
    end

    // stage 2: first multiply (lever sum for yaw, radius for wheel sums)
    assign coef2 = (cmd_reg[1] == mpk_pkg::CMD_BODY_TO_WHEEL) ? lever_sum_reg
                                                              : wheel_radius_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            prod2_next[i] = mpk_pkg::PROD_W'(op1_reg[i]) * mpk_pkg::PROD_W'(coef2);
        end
    end

    // stage 3: drop fraction bits (and divide by four for wheel-to-body), signed k*wz
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (cmd_reg[2] == mpk_pkg::CMD_BODY_TO_WHEEL)
            begin
                mag3_next[i] = prod2_reg[i][mpk_pkg::FRAC_W +: mpk_pkg::MAG3_W];
            end
            else
            begin
                mag3_next[i] = prod2_reg[i][mpk_pkg::QUAD_W +: mpk_pkg::MAG3_W];
            end
        end
        kw3_next = neg2_reg[0] ? -mpk_pkg::MAG_W'(mag3_next[0])
                               :  mpk_pkg::MAG_W'(mag3_next[0]);
    end

    // stage 4: wheel sums for body-to-wheel, lane routing for wheel-to-body
    assign ab_sum_w = mpk_pkg::MAG_W'(ab_sum3_reg);
    assign ab_dif_w = mpk_pkg::MAG_W'(ab_dif3_reg);

    assign x4[0] = ab_sum_w - kw3_reg;
    assign x4[1] = ab_dif_w + kw3_reg;
    assign x4[2] = ab_dif_w - kw3_reg;
    assign x4[3] = ab_sum_w + kw3_reg;

    always_comb
    begin
        for (int j = 0; j < mpk_pkg::LANES; j++)
        begin
            if (cmd_reg[3] == mpk_pkg::CMD_BODY_TO_WHEEL)
            begin
                neg4_next[j]  = x4[j][mpk_pkg::MAG_W-1];
                mag4_next[j]  = x4[j][mpk_pkg::MAG_W-1] ? -x4[j] : x4[j];
                coef4_next[j] = inv_wheel_radius_reg;
            end
            else if (j < 3)
            begin
                neg4_next[j]  = neg3_reg[j];
                mag4_next[j]  = mpk_pkg::MAG_W'(mag3_reg[j]);
                coef4_next[j] = (j == 2) ? inv_lever_sum_reg : mpk_pkg::COEF_ONE;
            end
            else
            begin
                neg4_next[j]  = 1'b0;
                mag4_next[j]  = '0;
                coef4_next[j] = mpk_pkg::COEF_ONE;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            op1_reg     <= op1_next;
            neg1_reg    <= neg1_next;
            ab_sum1_reg <= ab_sum_next;
            ab_dif1_reg <= ab_dif_next;
        end
        if (en[2])
        begin
            prod2_reg   <= prod2_next;
            neg2_reg    <= neg1_reg;
            ab_sum2_reg <= ab_sum1_reg;
            ab_dif2_reg <= ab_dif1_reg;
        end
        if (en[3])
        begin
            mag3_reg    <= mag3_next;
            neg3_reg    <= neg2_reg;
            kw3_reg     <= kw3_next;
            ab_sum3_reg <= ab_sum2_reg;
            ab_dif3_reg <= ab_dif2_reg;
        end
        if (en[4])
        begin
            mag4_reg  <= mag4_next;
            neg4_reg  <= neg4_next;
            coef4_reg <= coef4_next;
        end
    end

    // stages 5 to 7 in the lanes
    assign lane_ctl.en_mul = en[5];
    assign lane_ctl.en_add = en[6];
    assign lane_ctl.en_sat = en[7];

    for (genvar g = 0; g < mpk_pkg::LANES; g++)
    begin : g_lane
        mpk_sat_lane u_lane
        (
            .clk    (clk),
            .ctl    (lane_ctl),
            .mag    (mag4_reg[g]),
            .neg    (neg4_reg[g]),
            .coef   (coef4_reg[g]),
            .result (lane_res[g]),
            .sat    (lane_sat[g])
        );
    end

    assign m_tdata    = {lane_res[3], lane_res[2], lane_res[1], lane_res[0]};
    assign m_tuser[0] = |lane_sat;

`ifndef SYNTHESIS
    a_backpressure_full : assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (&vld_reg))
        else $error("input stalled with an empty stage");

    a_body_d_zero : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (cmd_reg[NS] == mpk_pkg::CMD_WHEEL_TO_BODY)
        |-> (m_tdata[4*DW-1:3*DW] == '0))
        else $error("out_d not zero for wheel-to-body word");

    a_sat_extreme : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0]
        |-> (m_tdata[DW-1:0] == mpk_pkg::SAT_POS || m_tdata[DW-1:0] == mpk_pkg::SAT_NEG
          || m_tdata[2*DW-1:DW] == mpk_pkg::SAT_POS
          || m_tdata[2*DW-1:DW] == mpk_pkg::SAT_NEG
          || m_tdata[3*DW-1:2*DW] == mpk_pkg::SAT_POS
          || m_tdata[3*DW-1:2*DW] == mpk_pkg::SAT_NEG
          || m_tdata[4*DW-1:3*DW] == mpk_pkg::SAT_POS
          || m_tdata[4*DW-1:3*DW] == mpk_pkg::SAT_NEG))
        else $error("saturation flagged without a clipped result");
`endif

endmodule

### hdl/mpk_sat_lane.sv
// Back end of one result lane: split scaling multiply, shift, sign and saturation.
module mpk_sat_lane
(
    input  logic                                clk,
    input  mpk_pkg::lane_ctl_t                  ctl,
    input  logic [mpk_pkg::MAG_W-1:0]           mag,
    input  logic                                neg,
    input  logic [mpk_pkg::COEF_W-1:0]          coef,
    output logic [mpk_pkg::DATA_W-1:0]          result,
    output logic                                sat
);

    logic [mpk_pkg::PP_W-1:0]   pp_lo_reg;
    logic [mpk_pkg::PP_W-1:0]   pp_hi_reg;
    logic [mpk_pkg::PP_W-1:0]   pp_lo_next;
    logic [mpk_pkg::PP_W-1:0]   pp_hi_next;
    logic                       neg5_reg;
    logic [mpk_pkg::FULL_W-1:0] full;
    logic [mpk_pkg::RES_W-1:0]  res_mag_reg;
    logic [mpk_pkg::RES_W-1:0]  res_mag_next;
    logic                       neg6_reg;
    logic [mpk_pkg::DATA_W-1:0] result_reg;
    logic [mpk_pkg::DATA_W-1:0] result_next;
    logic                       sat_reg;
    logic                       sat_next;

    // two 24-bit slices of the magnitude against the coefficient
    assign pp_lo_next = mpk_pkg::PP_W'(mag[mpk_pkg::HALF_W-1:0]) * mpk_pkg::PP_W'(coef);
    assign pp_hi_next = mpk_pkg::PP_W'(mag[mpk_pkg::MAG_W-1:mpk_pkg::HALF_W])
                      * mpk_pkg::PP_W'(coef);

    assign full = {pp_hi_reg, {mpk_pkg::HALF_W{1'b0}}} + mpk_pkg::FULL_W'(pp_lo_reg);
    assign res_mag_next = full[mpk_pkg::FULL_W-1:mpk_pkg::FRAC_W];

    always_comb
    begin
        sat_next    = 1'b0;
        result_next = res_mag_reg[mpk_pkg::DATA_W-1:0];
        if (neg6_reg)
        begin
            if (res_mag_reg > mpk_pkg::RES_W'(mpk_pkg::SAT_NEG))
            begin
                sat_next    = 1'b1;
                result_next = mpk_pkg::SAT_NEG;
            end
            else
            begin
                result_next = -res_mag_reg[mpk_pkg::DATA_W-1:0];
            end
        end
        else if (res_mag_reg > mpk_pkg::RES_W'(mpk_pkg::SAT_POS))
        begin
            sat_next    = 1'b1;
            result_next = mpk_pkg::SAT_POS;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en_mul)
        begin
            pp_lo_reg <= pp_lo_next;
            pp_hi_reg <= pp_hi_next;
            neg5_reg  <= neg;
        end
        if (ctl.en_add)
        begin
            res_mag_reg <= res_mag_next;
            neg6_reg    <= neg5_reg;
        end
        if (ctl.en_sat)
        begin
            result_reg <= result_next;
            sat_reg    <= sat_next;
        end
    end

    assign result = result_reg;
    assign sat    = sat_reg;

endmodule
